// ===== rtl/mcls_pkg.sv =====
// Shared types, codes and the median level function for the median level classifier.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package mcls_pkg;

  localparam int SAMPLE_W = 12;
  localparam int THR_W    = 8;
  localparam int LEVEL_W  = 2;
  localparam int CFG_IDX_W = 2;

  typedef logic signed [SAMPLE_W-1:0] sample_t;
  typedef logic signed [THR_W-1:0]    thr_t;
  typedef logic [LEVEL_W-1:0]         level_t;
  typedef logic [CFG_IDX_W-1:0]       cfg_idx_t;

  // Level codes
  localparam level_t LEVEL_LOW  = 2'd0;
  localparam level_t LEVEL_HIGH = 2'd1;
  localparam level_t LEVEL_MID  = 2'd2;

  // Register indexes
  localparam cfg_idx_t REG_UPPER = 2'd0;
  localparam cfg_idx_t REG_LOWER = 2'd1;

  // Reset values of the thresholds, whole degrees
  localparam thr_t UPPER_RST = 8'sd31;
  localparam thr_t LOWER_RST = 8'sd30;

  // Controller states
  typedef enum logic [1:0] {
    ST_FILL,
    ST_CLASSIFY,
    ST_DRAIN
  } state_t;

  // Per-cycle command to every cell of the chain
  typedef struct packed {
    logic ins;    // insert the broadcast sample
    logic shift;  // move every value one cell towards the output
  } cell_ctrl_t;

  // Upper limit is degrees*10, lower limit degrees*8 (0.8 of the lower in tenths)
  function automatic level_t level_of(sample_t med, thr_t up, thr_t lo);
    logic signed [SAMPLE_W:0] m;
    logic signed [SAMPLE_W:0] ue;
    logic signed [SAMPLE_W:0] le;
    logic signed [SAMPLE_W:0] u10;
    logic signed [SAMPLE_W:0] l8;
    level_t lvl;
    m   = {med[SAMPLE_W-1], med};
    ue  = {{(SAMPLE_W+1-THR_W){up[THR_W-1]}}, up};
    le  = {{(SAMPLE_W+1-THR_W){lo[THR_W-1]}}, lo};
    u10 = (ue <<< 3) + (ue <<< 1);
    l8  = le <<< 3;
    priority if (m >= u10) begin
      lvl = LEVEL_HIGH;
    end else if (m <= l8) begin
      lvl = LEVEL_LOW;
    end else begin
      lvl = LEVEL_MID;
    end
    return lvl;
  endfunction

endpackage

`default_nettype wire

// ===== rtl/median_of_nine_level_classifier.sv =====
// Top level: insertion chain of cells, fill/drain controller and threshold registers.
// Depends on mcls_pkg and mcls_cell.
`timescale 1ns / 1ps
`default_nettype none

// Collects COUNT signed 12-bit samples into an ascending chain of COUNT cells, one
// sample per clock while the set fills (ties go behind earlier equal values). The
// request that completes the set is followed by the classify state, in which the median
// (entry (COUNT-1)/2) is classified against the thresholds, and then the run of COUNT
// results leaves smallest first, one per cycle unless out_stall holds it, with
// out_last on the largest. in_stall stays high after the completing request until the
// last result is taken. The thresholds are written through the cfg port (always ready);
// the user must write them only while the block is idle: the block does not enforce it.
module median_of_nine_level_classifier #(
  parameter int COUNT = 9
) (
  input  wire                clk,
  input  wire                rst_n,
  input  wire                in_valid,
  output logic               in_stall,
  input  mcls_pkg::sample_t  in_sample,
  output logic               out_valid,
  input  wire                out_stall,
  output mcls_pkg::sample_t  out_sorted_value,
  output mcls_pkg::level_t   out_level,
  output logic               out_last,
  input  wire                cfg_valid,
  output logic               cfg_ready,
  input  mcls_pkg::cfg_idx_t cfg_index,
  input  mcls_pkg::thr_t     cfg_data
);
  import mcls_pkg::*;

  localparam int CNT_W = $clog2(COUNT + 1);
  localparam int MID   = (COUNT - 1) / 2;

  state_t     state_r, state_nxt;
  logic [CNT_W-1:0] fill_r, fill_nxt;
  logic [CNT_W-1:0] rem_r, rem_nxt;
  level_t     level_r, level_nxt;
  thr_t       upper_r, lower_r;
  cell_ctrl_t ctrl;
  logic       in_acc;
  logic       out_acc;

  sample_t    cell_val  [COUNT];
  logic       cell_take [COUNT];

  assign in_acc  = in_valid && !in_stall;
  assign out_acc = out_valid && !out_stall;

  // Next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_FILL: begin
        if (in_acc && (fill_r == CNT_W'(COUNT - 1))) state_nxt = ST_CLASSIFY;
      end
      ST_CLASSIFY: state_nxt = ST_DRAIN;
      ST_DRAIN: begin
        if (out_acc && (rem_r == CNT_W'(1))) state_nxt = ST_FILL;
      end
      default: state_nxt = ST_FILL;
    endcase
  end

  // Outputs of the controller
  always_comb begin
    in_stall   = 1'b1;
    out_valid  = 1'b0;
    ctrl.ins   = 1'b0;
    ctrl.shift = 1'b0;
    unique case (state_r)
      ST_FILL: begin
        in_stall = 1'b0;
        ctrl.ins = in_valid;
      end
      ST_CLASSIFY: begin
      end
      ST_DRAIN: begin
        out_valid  = 1'b1;
        ctrl.shift = !out_stall;
      end
      default: begin
      end
    endcase
  end

  // Counters and level
  always_comb begin
    fill_nxt  = fill_r;
    rem_nxt   = rem_r;
    level_nxt = level_r;
    if (in_acc) begin
      fill_nxt = (fill_r == CNT_W'(COUNT - 1)) ? '0 : fill_r + CNT_W'(1);
    end
    if (state_r == ST_CLASSIFY) begin
      level_nxt = level_of(cell_val[MID], upper_r, lower_r);
      rem_nxt   = CNT_W'(COUNT);
    end else if (out_acc) begin
      rem_nxt = rem_r - CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_FILL;
      fill_r  <= '0;
      rem_r   <= '0;
    end else begin
      state_r <= state_nxt;
      fill_r  <= fill_nxt;
      rem_r   <= rem_nxt;
    end
  end

  always_ff @(posedge clk) begin
    level_r <= level_nxt;
  end

  // Threshold registers
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      upper_r <= UPPER_RST;
      lower_r <= LOWER_RST;
    end else if (cfg_valid && cfg_ready) begin
      if (cfg_index == REG_UPPER) upper_r <= cfg_data;
      if (cfg_index == REG_LOWER) lower_r <= cfg_data;
    end
  end

  // Chain of cells; cell 0 faces the output
  for (genvar i = 0; i < COUNT; i++) begin : g_cell
    sample_t lv;
    sample_t rv;
    logic    lt;
    if (i == 0) begin : g_head
      assign lv = '0;
      assign lt = 1'b0;
    end else begin : g_body
      assign lv = cell_val[i-1];
      assign lt = cell_take[i-1];
    end
    if (i == COUNT - 1) begin : g_tail
      assign rv = '0;
    end else begin : g_inner
      assign rv = cell_val[i+1];
    end

    mcls_cell u_cell (
      .clk       (clk),
      .ctrl      (ctrl),
      .occ       (CNT_W'(i) < fill_r),
      .sample    (in_sample),
      .left_val  (lv),
      .left_take (lt),
      .right_val (rv),
      .val       (cell_val[i]),
      .take      (cell_take[i])
    );
  end

  assign out_sorted_value = cell_val[0];
  assign out_level        = level_r;
  assign out_last         = (rem_r == CNT_W'(1));

endmodule

`default_nettype wire

// ===== rtl/mcls_cell.sv =====
// One cell of the insertion chain: holds one sorted value.
// Depends on mcls_pkg.
`timescale 1ns / 1ps
`default_nettype none

module mcls_cell (
  input  wire                 clk,
  input  mcls_pkg::cell_ctrl_t ctrl,
  input  wire                 occ,        // cell holds a value of the current set
  input  mcls_pkg::sample_t   sample,     // broadcast new sample
  input  mcls_pkg::sample_t   left_val,   // value of the neighbour nearer the output
  input  wire                 left_take,  // that neighbour takes the sample
  input  mcls_pkg::sample_t   right_val,  // value of the neighbour further from the output
  output mcls_pkg::sample_t   val,
  output logic                take
);
  import mcls_pkg::*;

  sample_t val_r;
  sample_t val_nxt;

  // New sample goes behind equal values, so only a strictly smaller one displaces
  assign take = !occ || (sample < val_r);

  always_comb begin
    val_nxt = val_r;
    priority if (ctrl.shift) begin
      val_nxt = right_val;
    end else if (ctrl.ins && take) begin
      val_nxt = left_take ? left_val : sample;
    end else begin
      val_nxt = val_r;
    end
  end

  always_ff @(posedge clk) begin
    val_r <= val_nxt;
  end

  assign val = val_r;

endmodule

`default_nettype wire

// ===== rtl/mcls_checker.sv =====
// Port-level checks for the median level classifier, bound to the top level.
// Depends on mcls_pkg and median_of_nine_level_classifier.
`timescale 1ns / 1ps
`default_nettype none

module mcls_checker (
  input wire                clk,
  input wire                rst_n,
  input wire                in_stall,
  input wire                out_valid,
  input wire                out_stall,
  input mcls_pkg::sample_t  out_sorted_value,
  input mcls_pkg::level_t   out_level,
  input wire                out_last
);
  import mcls_pkg::*;

  // A stalled result holds
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_sorted_value))
    else $error("stalled result changed");

  // No new sample is taken while a run drains
  a_no_in: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> in_stall)
    else $error("input open during run");

  // A run continues without gaps and keeps one level
  a_run: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_stall && !out_last |=> out_valid && $stable(out_level))
    else $error("run broken or level changed");

  // The last result closes the run
  a_end: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_stall && out_last |=> !out_valid)
    else $error("result after last");

endmodule

bind median_of_nine_level_classifier mcls_checker u_mcls_checker (.*);

`default_nettype wire

// ===== tb/tb_median_of_nine_level_classifier.sv =====
`timescale 1ns / 1ps
// Testbench for median_of_nine_level_classifier: sorted runs, median levels and last flags.
// Depends on mcls_pkg and the block's RTL. Predicts each run from accepted requests.

module tb_median_of_nine_level_classifier;
  import mcls_pkg::*;

  localparam int COUNT     = 9;
  localparam int MEDIAN    = (COUNT - 1) / 2;
  localparam int SETTLE    = 2 * COUNT + 4;
  localparam int CYCLE_CAP = 400000;

  typedef struct {
    sample_t value;
    level_t  level;
    logic    last;
  } sorted_result_t;

  // DUT inputs, known from time zero
  logic     clk       = 1'b0;
  logic     rst_n     = 1'b0;
  logic     in_valid  = 1'b0;
  sample_t  in_sample = '0;
  logic     out_stall = 1'b0;
  logic     cfg_valid = 1'b0;
  cfg_idx_t cfg_index = REG_UPPER;
  thr_t     cfg_data  = '0;

  // DUT outputs
  logic    in_stall;
  logic    out_valid;
  sample_t out_sorted_value;
  level_t  out_level;
  logic    out_last;
  logic    cfg_ready;

  // Predictor state: samples of the set being filled, expected results and the thresholds in degrees
  sample_t        held_set[$];
  sorted_result_t sorted_run_q[$];
  thr_t           upper_deg = UPPER_RST;
  thr_t           lower_deg = LOWER_RST;

  // Run control and bookkeeping
  int idle_pct     = 0;
  int stall_pct    = 0;
  int hold_left    = 0;
  int cycles       = 0;
  int err_count    = 0;
  int items_sent   = 0;
  int results_seen = 0;
  int cfg_writes   = 0;

  median_of_nine_level_classifier #(.COUNT(COUNT)) dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_sample        (in_sample),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_sorted_value (out_sorted_value),
    .out_level        (out_level),
    .out_last         (out_last),
    .cfg_valid        (cfg_valid),
    .cfg_ready        (cfg_ready),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data)
  );

  initial begin
    forever #4 clk = ~clk;
  end

  // Watchdog
  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_CAP) begin
      $display("tb_median_of_nine_level_classifier: done, errors");
      $finish;
    end
  end

  task automatic report_mismatch(string msg);
    $display("MISMATCH @%0d: %s", cycles, msg);
    err_count++;
  endtask

  // Level of a full set, from its median and the current thresholds
  function automatic level_t median_level(sample_t med);
    int m;
    m = med;
    if (m >= int'(upper_deg) * 10) return LEVEL_HIGH;
    if (m <= int'(lower_deg) * 8) return LEVEL_LOW;
    return LEVEL_MID;
  endfunction

  // Insert behind equal values; a full set becomes COUNT expected results
  function automatic void accept_sample(sample_t s);
    int     pos;
    level_t lvl;
    pos = 0;
    while (pos < held_set.size() && held_set[pos] <= s) pos++;
    held_set.insert(pos, s);
    if (held_set.size() == COUNT) begin
      lvl = median_level(held_set[MEDIAN]);
      for (int k = 0; k < COUNT; k++)
        sorted_run_q.push_back('{value: held_set[k], level: lvl, last: (k == COUNT - 1)});
      held_set.delete();
    end
  endfunction

  // Mostly values around the two limits so medians land on and beside them
  function automatic sample_t pick_sample();
    int r;
    int d;
    r = $urandom_range(99);
    d = $urandom_range(4);
    if (r < 35) return sample_t'(int'(upper_deg) * 10 + d - 2);
    if (r < 70) return sample_t'(int'(lower_deg) * 8 + d - 2);
    if (r < 90) return sample_t'(int'($urandom_range(1800)) - 550);
    return sample_t'($urandom);
  endfunction

  function automatic thr_t pick_threshold();
    if ($urandom_range(3) == 0) return thr_t'($urandom);
    return thr_t'(int'($urandom_range(180)) - 55);
  endfunction

  // Result checker
  always @(posedge clk) begin : check_results
    sorted_result_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (sorted_run_q.size() == 0) begin
        report_mismatch($sformatf("result %0d with nothing expected", out_sorted_value));
      end else begin
        want = sorted_run_q.pop_front();
        results_seen++;
        if (out_sorted_value !== want.value)
          report_mismatch($sformatf("value %0d, want %0d", out_sorted_value, want.value));
        if (out_level !== want.level)
          report_mismatch($sformatf("level %0d, want %0d (value %0d)",
                                    out_level, want.level, want.value));
        if (out_last !== want.last)
          report_mismatch($sformatf("last %0b, want %0b (value %0d)",
                                    out_last, want.last, want.value));
      end
    end
  end

  // Receiver: long hold-off when asked, random stalls otherwise
  always @(posedge clk) begin
    if (hold_left > 0) begin
      out_stall <= 1'b1;
      hold_left = hold_left - 1;
    end else begin
      out_stall <= ($urandom_range(99) < stall_pct);
    end
  end

  // One request on the input channel, with an optional random gap first
  task automatic send_sample(sample_t s);
    while ($urandom_range(99) < idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid  <= 1'b1;
    in_sample <= s;
    do @(posedge clk); while (in_stall);
    accept_sample(s);
    items_sent++;
  endtask

  // Stop sending, let every expected result out, then allow the block to settle
  task automatic wait_drained();
    in_valid <= 1'b0;
    while (sorted_run_q.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic write_reg(cfg_idx_t idx, thr_t val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    case (idx)
      REG_UPPER: upper_deg = val;
      REG_LOWER: lower_deg = val;
      default: ;
    endcase
    cfg_writes++;
    @(posedge clk);
  endtask

  // Reset thresholds: median on the upper limit, on the lower limit, and between;
  // field extremes, ties and out-of-range samples
  task automatic test_directed_levels();
    int seq[27] = '{2047, -2048, 310, 310, 0, -1, 1250, -550, 310,
                    240, 241, 239, 240, -100, 500, 300, 100, 240,
                    300, 300, 2000, 300, 241, 300, 309, 250, 300};
    foreach (seq[i]) send_sample(sample_t'(seq[i]));
    wait_drained();
  endtask

  // Threshold extremes, plus writes to the unused indexes which must change nothing
  task automatic test_threshold_extremes();
    int ups[6] = '{-128, 127, 127, -128, -55, 125};
    int los[6] = '{-128, 127, -128, 127, 125, -55};
    foreach (ups[i]) begin
      write_reg(REG_UPPER, thr_t'(ups[i]));
      write_reg(REG_LOWER, thr_t'(los[i]));
      repeat (COUNT) send_sample(pick_sample());
      wait_drained();
    end
    write_reg(REG_UPPER, 8'sd31);
    write_reg(REG_LOWER, 8'sd30);
    write_reg(cfg_idx_t'(2), thr_t'($urandom));
    write_reg(cfg_idx_t'(3), thr_t'($urandom));
    repeat (2 * COUNT) send_sample(pick_sample());
    wait_drained();
  endtask

  // Receiver holds off while the sender keeps offering, then the sender waits for a drain
  task automatic test_backpressure();
    idle_pct  = 0;
    stall_pct = 0;
    hold_left = 120;
    repeat (3 * COUNT) send_sample(pick_sample());
    wait_drained();
    repeat (COUNT) send_sample(pick_sample());
    wait_drained();
    repeat (COUNT) send_sample(pick_sample());
    wait_drained();
  endtask

  // Random samples under four idling patterns, new thresholds between whole sets
  task automatic test_random_phases();
    int in_gap[4]  = '{0, 80, 0, 9};
    int out_gap[4] = '{0, 0, 80, 9};
    foreach (in_gap[p]) begin
      idle_pct  = in_gap[p];
      stall_pct = out_gap[p];
      repeat (2 * COUNT) send_sample(pick_sample());
      wait_drained();
      write_reg(REG_UPPER, pick_threshold());
      write_reg(REG_LOWER, pick_threshold());
      if ($urandom_range(1)) write_reg(cfg_idx_t'($urandom_range(3, 2)), thr_t'($urandom));
    end
    idle_pct  = 0;
    stall_pct = 0;
  endtask

  initial begin
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_directed_levels();
    test_threshold_extremes();
    test_backpressure();
    test_random_phases();
    wait_drained();

    if (sorted_run_q.size() != 0)
      report_mismatch($sformatf("%0d results never arrived", sorted_run_q.size()));
    $display("Run: %0d samples sent, %0d sorted results checked, %0d register writes.",
             items_sent, results_seen, cfg_writes);
    $display("Covered extreme thresholds, limit ties, a long hold-off, four idling mixes.");
    if (err_count == 0) begin
      $display("tb_median_of_nine_level_classifier: done, clean");
    end else begin
      $display("tb_median_of_nine_level_classifier: done, errors");
    end
    $finish;
  end

endmodule

// ===== files.f =====
rtl/mcls_pkg.sv
rtl/mcls_cell.sv
rtl/median_of_nine_level_classifier.sv
rtl/mcls_checker.sv
tb/tb_median_of_nine_level_classifier.sv
